/* hw/rtl/irps_pkg.sv */
`default_nettype none

package irps_pkg;

  // Horner coefficients of the odd sine polynomial, Q30.
  localparam logic [30:0] K1 = 31'd1686629713;
  localparam logic [30:0] K3 = 31'd693598668;
  localparam logic [30:0] K5 = 31'd85569306;
  localparam logic [30:0] K7 = 31'd5026995;
  localparam logic [30:0] K9 = 31'd172272;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_PHASE_STEP    = 3'd0,
    CFG_STATE_COEFF   = 3'd1,
    CFG_VOLTAGE_COEFF = 3'd2,
    CFG_DC_LINK       = 3'd3,
    CFG_GRID_PEAK     = 3'd4,
    CFG_REF_PEAK      = 3'd5,
    CFG_STEPS         = 3'd6
  } cfg_idx_e;

  // Values after reset.
  localparam logic [31:0] RST_PHASE_STEP    = 32'd515396;
  localparam logic [30:0] RST_STATE_COEFF   = 31'd1073714838;
  localparam logic [31:0] RST_VOLTAGE_COEFF = 32'd1431638;
  localparam logic [19:0] RST_DC_LINK       = 20'd102400;
  localparam logic [19:0] RST_GRID_PEAK     = 20'd79649;
  localparam logic [23:0] RST_REF_PEAK      = 24'd842562;
  localparam logic [9:0]  RST_STEPS         = 10'd50;

endpackage

`default_nettype wire

/* hw/rtl/inverter_rl_plant_step.sv */
`default_nettype none

// Full-bridge inverter with an R-L grid filter, stepped once per simulation tick.
// Each accepted word carries the four gate states. The block advances the grid
// phase, evaluates the sine by polynomial, scales it to the grid voltage and to the
// reference current, and applies the Tustin R-L recurrence to the inductor current,
// which saturates at the 32-bit bounds. It returns one word per tick, with tlast
// marking the end of a PWM period. All multiplications go through a single registered
// 33 by 33 bit signed multiplier driven by a small sequencer. That takes eleven
// products, each registered in state ST_MUL and used in state ST_USE; then state
// ST_OUT loads the result word into the output register once that register is free.
// The block takes no new tick while one is in progress. A new tick is accepted once
// the previous result has been moved to the output register, even while that word
// still waits to be taken downstream. Configuration writes take effect at once and
// should only be made while the block is idle.
module inverter_rl_plant_step #(
  parameter int SINE_INDEX_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Bits from the lowest up: gate_one, gate_two, gate_three, gate_four, zero fill.
  input  wire logic [7:0]  s_axis_tdata,
  // Output stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Bits from the lowest up: grid_voltage (21), reference_current (25),
  // inductor_current (32), zero fill (2).
  output logic [79:0]      m_axis_tdata,
  // cycle_end.
  output logic             m_axis_tlast
);

  localparam int QB = SINE_INDEX_BITS - 2;
  localparam int QSIZE = 1 << QB;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_USE,
    ST_OUT
  } state_e;

  // One product per operation, in this order.
  typedef enum logic [3:0] {
    OP_X2,
    OP_P7,
    OP_P5,
    OP_P3,
    OP_P1,
    OP_SIN,
    OP_VG,
    OP_IREF,
    OP_ISTATE,
    OP_VIND,
    OP_VPREV
  } op_e;

  // Configuration registers.
  logic [31:0] phase_step_q;
  logic [30:0] state_coeff_q;
  logic [31:0] voltage_coeff_q;
  logic [19:0] dc_link_q;
  logic [19:0] grid_peak_q;
  logic [23:0] ref_peak_q;
  logic [9:0]  steps_q;

  // Plant state.
  logic [PHASE_BITS-1:0] phase_q;
  logic [9:0]            tick_q;
  logic signed [21:0]    prev_vind_q;
  logic signed [31:0]    cur_q;

  // Working registers of one tick.
  state_e             state_q;
  op_e                op_q;
  logic signed [65:0] prod_q;
  logic [30:0]        x_q;
  logic [30:0]        x2_q;
  logic [30:0]        p_q;
  logic               neg_q;
  logic [14:0]        smag_q;
  logic signed [20:0] vf_q;
  logic signed [20:0] vg_q;
  logic signed [24:0] iref_q;
  logic signed [21:0] vind_q;
  logic signed [35:0] acc_q;
  logic               cyc_q;

  // Output register.
  logic        out_valid_q;
  logic [79:0] out_data_q;
  logic        out_last_q;

  // Start of a tick: phase, sine argument, tick counter and bridge voltage.
  logic [PHASE_BITS-1:0]      phase_n;
  logic [SINE_INDEX_BITS-1:0] sin_idx;
  logic [QB-1:0]              k_low;
  logic [QB:0]                k_mir;
  logic [30:0]                x_n;
  logic [9:0]                 tick_inc;
  logic                       g1, g2, g3, g4;
  logic signed [20:0]         vf_n;

  always_comb begin
    phase_n  = phase_q + phase_step_q[PHASE_BITS-1:0];
    sin_idx  = phase_n[PHASE_BITS-1 -: SINE_INDEX_BITS];
    k_low    = sin_idx[QB-1:0];
    if (sin_idx[QB]) begin
      k_mir = (QB+1)'(QSIZE) - {1'b0, k_low};
    end else begin
      k_mir = {1'b0, k_low};
    end
    x_n      = {k_mir, {(30-QB){1'b0}}};
    tick_inc = tick_q + 10'd1;
    g1       = s_axis_tdata[0];
    g2       = s_axis_tdata[1];
    g3       = s_axis_tdata[2];
    g4       = s_axis_tdata[3];
    if (g1 && g4) begin
      vf_n = $signed({1'b0, dc_link_q});
    end else if (g2 && g3) begin
      vf_n = -$signed({1'b0, dc_link_q});
    end else begin
      vf_n = '0;
    end
  end

  // Operand selection of the shared multiplier.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_d;

  always_comb begin
    unique case (op_q)
      OP_X2: begin
        mul_a = $signed({2'b0, x_q});
        mul_b = $signed({2'b0, x_q});
      end
      OP_P7, OP_P5, OP_P3, OP_P1: begin
        mul_a = $signed({2'b0, p_q});
        mul_b = $signed({2'b0, x2_q});
      end
      OP_SIN: begin
        mul_a = $signed({2'b0, p_q});
        mul_b = $signed({2'b0, x_q});
      end
      OP_VG: begin
        mul_a = $signed({13'b0, grid_peak_q});
        mul_b = $signed({18'b0, smag_q});
      end
      OP_IREF: begin
        mul_a = $signed({9'b0, ref_peak_q});
        mul_b = $signed({18'b0, smag_q});
      end
      OP_ISTATE: begin
        mul_a = $signed({2'b0, state_coeff_q});
        mul_b = 33'(cur_q);
      end
      OP_VIND: begin
        mul_a = $signed({1'b0, voltage_coeff_q});
        mul_b = 33'(vind_q);
      end
      OP_VPREV: begin
        mul_a = $signed({1'b0, voltage_coeff_q});
        mul_b = 33'(prev_vind_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Results taken from the registered product.
  logic [30:0]        prod_q30;
  logic [34:0]        sin_rnd;
  logic [14:0]        smag_n;
  logic [38:0]        amp_rnd;
  logic [23:0]        amp_mag;
  logic signed [20:0] vg_n;
  logic signed [65:0] rnd30;
  logic signed [65:0] rnd24;
  logic signed [35:0] term30;
  logic signed [35:0] term24;
  logic signed [35:0] acc_fin;
  logic signed [31:0] cur_sat;

  always_comb begin
    prod_q30 = prod_q[60:30];
    sin_rnd  = {1'b0, prod_q[63:30]} + 35'd16384;
    if (sin_rnd[34:15] > 20'd32767) begin
      smag_n = 15'd32767;
    end else begin
      smag_n = sin_rnd[29:15];
    end
    amp_rnd  = prod_q[38:0] + 39'd16384;
    amp_mag  = amp_rnd[38:15];
    if (neg_q) begin
      vg_n = -$signed({1'b0, amp_mag[19:0]});
    end else begin
      vg_n = $signed({1'b0, amp_mag[19:0]});
    end
    rnd30    = prod_q + (66'sd1 <<< 29);
    rnd24    = prod_q + (66'sd1 <<< 23);
    term30   = rnd30[65:30];
    term24   = rnd24[59:24];
    acc_fin  = acc_q + term24;
    if (acc_fin > 36'sd2147483647) begin
      cur_sat = 32'sh7fffffff;
    end else if (acc_fin < -36'sd2147483648) begin
      cur_sat = 32'sh80000000;
    end else begin
      cur_sat = acc_fin[31:0];
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q    <= irps_pkg::RST_PHASE_STEP;
      state_coeff_q   <= irps_pkg::RST_STATE_COEFF;
      voltage_coeff_q <= irps_pkg::RST_VOLTAGE_COEFF;
      dc_link_q       <= irps_pkg::RST_DC_LINK;
      grid_peak_q     <= irps_pkg::RST_GRID_PEAK;
      ref_peak_q      <= irps_pkg::RST_REF_PEAK;
      steps_q         <= irps_pkg::RST_STEPS;
      phase_q         <= '0;
      tick_q          <= '0;
      prev_vind_q     <= '0;
      cur_q           <= '0;
      state_q         <= ST_IDLE;
      op_q            <= OP_X2;
      prod_q          <= '0;
      x_q             <= '0;
      x2_q            <= '0;
      p_q             <= '0;
      neg_q           <= 1'b0;
      smag_q          <= '0;
      vf_q            <= '0;
      vg_q            <= '0;
      iref_q          <= '0;
      vind_q          <= '0;
      acc_q           <= '0;
      cyc_q           <= 1'b0;
      out_valid_q     <= 1'b0;
      out_data_q      <= '0;
      out_last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (irps_pkg::cfg_idx_e'(cfg_idx_i))
          irps_pkg::CFG_PHASE_STEP:    phase_step_q    <= cfg_data_i;
          irps_pkg::CFG_STATE_COEFF:   state_coeff_q   <= cfg_data_i[30:0];
          irps_pkg::CFG_VOLTAGE_COEFF: voltage_coeff_q <= cfg_data_i;
          irps_pkg::CFG_DC_LINK:       dc_link_q       <= cfg_data_i[19:0];
          irps_pkg::CFG_GRID_PEAK:     grid_peak_q     <= cfg_data_i[19:0];
          irps_pkg::CFG_REF_PEAK:      ref_peak_q      <= cfg_data_i[23:0];
          irps_pkg::CFG_STEPS:         steps_q         <= cfg_data_i[9:0];
          default: ;
        endcase
      end

      // A taken word leaves the output register unless a new one replaces it.
      if (out_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            phase_q <= phase_n;
            x_q     <= x_n;
            neg_q   <= sin_idx[QB+1];
            p_q     <= irps_pkg::K9;
            vf_q    <= vf_n;
            if (tick_inc >= steps_q) begin
              tick_q <= '0;
              cyc_q  <= 1'b1;
            end else begin
              tick_q <= tick_inc;
              cyc_q  <= 1'b0;
            end
            op_q    <= OP_X2;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_USE;
        end
        ST_USE: begin
          state_q <= (op_q == OP_VPREV) ? ST_OUT : ST_MUL;
          unique case (op_q)
            OP_X2: begin
              x2_q <= prod_q30;
              op_q <= OP_P7;
            end
            OP_P7: begin
              p_q  <= irps_pkg::K7 - prod_q30;
              op_q <= OP_P5;
            end
            OP_P5: begin
              p_q  <= irps_pkg::K5 - prod_q30;
              op_q <= OP_P3;
            end
            OP_P3: begin
              p_q  <= irps_pkg::K3 - prod_q30;
              op_q <= OP_P1;
            end
            OP_P1: begin
              p_q  <= irps_pkg::K1 - prod_q30;
              op_q <= OP_SIN;
            end
            OP_SIN: begin
              smag_q <= smag_n;
              op_q   <= OP_VG;
            end
            OP_VG: begin
              vg_q   <= vg_n;
              vind_q <= 22'(vf_q) - 22'(vg_n);
              op_q   <= OP_IREF;
            end
            OP_IREF: begin
              if (neg_q) begin
                iref_q <= -$signed({1'b0, amp_mag});
              end else begin
                iref_q <= $signed({1'b0, amp_mag});
              end
              op_q <= OP_ISTATE;
            end
            OP_ISTATE: begin
              acc_q <= term30;
              op_q  <= OP_VIND;
            end
            OP_VIND: begin
              acc_q <= acc_fin;
              op_q  <= OP_VPREV;
            end
            OP_VPREV: begin
              cur_q       <= cur_sat;
              prev_vind_q <= vind_q;
            end
            default: ;
          endcase
        end
        ST_OUT: begin
          // The result moves out once the output register is free.
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {2'b00, cur_q, iref_q, vg_q};
            out_last_q  <= cyc_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The index above the last register must be ignored by the block.
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

  // Gate patterns of a normal bridge: the diagonal pairs and both legs off.
  // Bit 0 is gate_one and bit 3 is gate_four.
  localparam logic [3:0] GATES_POSITIVE = 4'b1001;
  localparam logic [3:0] GATES_NEGATIVE = 4'b0110;
  localparam logic [3:0] GATES_OFF      = 4'b0000;

  // Delay from an accepted tick to its result word, used in the final wait.
  localparam int TICK_LATENCY = 23;
  // Length of the single long receiver hold-off.
  localparam int LONG_HOLD = 400;

  // One result word, split into its fields.
  typedef struct packed {
    logic signed [20:0] grid_v;
    logic signed [24:0] ref_i;
    logic signed [31:0] ind_i;
    logic               cyc_end;
  } plant_result_t;

  // Keeps its own copy of the plant registers and state, works out the word
  // that each accepted tick must produce and compares the words that arrive.
  class plant_scoreboard;
    logic [31:0]     phase_step;
    logic [30:0]     state_coeff;
    logic [31:0]     voltage_coeff;
    logic [19:0]     dc_link;
    logic [19:0]     grid_peak;
    logic [23:0]     ref_peak;
    logic [9:0]      steps_per_cycle;
    logic [31:0]     phase_acc;
    int              prev_vind;
    int              i_state;
    logic [9:0]      tick_count;
    plant_result_t   expected_words[$];
    int              fail_count;

    function new();
      phase_step      = irps_pkg::RST_PHASE_STEP;
      state_coeff     = irps_pkg::RST_STATE_COEFF;
      voltage_coeff   = irps_pkg::RST_VOLTAGE_COEFF;
      dc_link         = irps_pkg::RST_DC_LINK;
      grid_peak       = irps_pkg::RST_GRID_PEAK;
      ref_peak        = irps_pkg::RST_REF_PEAK;
      steps_per_cycle = irps_pkg::RST_STEPS;
      phase_acc       = '0;
      prev_vind       = 0;
      i_state         = 0;
      tick_count      = '0;
      fail_count      = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        irps_pkg::CFG_PHASE_STEP:    phase_step      = value;
        irps_pkg::CFG_STATE_COEFF:   state_coeff     = value[30:0];
        irps_pkg::CFG_VOLTAGE_COEFF: voltage_coeff   = value;
        irps_pkg::CFG_DC_LINK:       dc_link         = value[19:0];
        irps_pkg::CFG_GRID_PEAK:     grid_peak       = value[19:0];
        irps_pkg::CFG_REF_PEAK:      ref_peak        = value[23:0];
        irps_pkg::CFG_STEPS:         steps_per_cycle = value[9:0];
        default: ;
      endcase
    endfunction

    // Odd polynomial over a quarter wave in Q30, rounded to Q1.15; the other
    // quadrants are mirrored and negated.
    function int sine_q15(logic [9:0] idx);
      int unsigned     k;
      longint unsigned x, x2, p, s;
      int unsigned     mag;
      k = idx[7:0];
      if (idx[8]) begin
        k = 256 - k;
      end
      x  = 64'(k) << 22;
      x2 = (x * x) >> 30;
      p  = 64'(irps_pkg::K9);
      p  = 64'(irps_pkg::K7) - ((p * x2) >> 30);
      p  = 64'(irps_pkg::K5) - ((p * x2) >> 30);
      p  = 64'(irps_pkg::K3) - ((p * x2) >> 30);
      p  = 64'(irps_pkg::K1) - ((p * x2) >> 30);
      s  = (p * x) >> 30;
      s  = (s + 64'd16384) >> 15;
      mag = (s > 64'd32767) ? 32767 : int'(s);
      return idx[9] ? -int'(mag) : int'(mag);
    endfunction

    // Rounded magnitude product; the sign of the sine is put back afterwards.
    function int scale_peak(int unsigned amp, int s);
      longint unsigned m;
      m = (64'(amp) * 64'((s < 0) ? -s : s) + 64'd16384) >> 15;
      return (s < 0) ? -int'(m) : int'(m);
    endfunction

    // Adds half an LSB and shifts arithmetically, which rounds to nearest with ties towards +inf.
    function longint round_off(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function void note_tick(logic [3:0] gates);
      int            s, vg, iref, vf, vind;
      longint        acc;
      logic          cyc;
      plant_result_t r;
      phase_acc = phase_acc + phase_step;
      s    = sine_q15(phase_acc[31:22]);
      vg   = scale_peak(grid_peak, s);
      iref = scale_peak(ref_peak, s);
      tick_count = tick_count + 10'd1;
      cyc = 1'b0;
      if (tick_count >= steps_per_cycle) begin
        tick_count = '0;
        cyc = 1'b1;
      end
      // With every gate on the positive diagonal takes precedence.
      if (gates[0] && gates[3]) begin
        vf = int'(dc_link);
      end else if (gates[1] && gates[2]) begin
        vf = -int'(dc_link);
      end else begin
        vf = 0;
      end
      vind = vf - vg;
      acc = round_off(longint'(state_coeff) * longint'(i_state), 30)
          + round_off(longint'(voltage_coeff) * longint'(vind), 24)
          + round_off(longint'(voltage_coeff) * longint'(prev_vind), 24);
      if (acc > 64'sd2147483647) begin
        acc = 64'sd2147483647;
      end else if (acc < -64'sd2147483648) begin
        acc = -64'sd2147483648;
      end
      prev_vind = vind;
      i_state   = int'(acc);
      r.grid_v  = vg[20:0];
      r.ref_i   = iref[24:0];
      r.ind_i   = i_state;
      r.cyc_end = cyc;
      expected_words.push_back(r);
    endfunction

    function void check_word(logic [79:0] data, logic last);
      plant_result_t e;
      if (expected_words.size() == 0) begin
        $error("result word arrived with no tick outstanding");
        fail_count++;
        return;
      end
      e = expected_words.pop_front();
      if (data[20:0] !== e.grid_v) begin
        $error("grid_voltage: expected %0d, got %0d", $signed(e.grid_v),
               $signed(data[20:0]));
        fail_count++;
      end
      if (data[45:21] !== e.ref_i) begin
        $error("reference_current: expected %0d, got %0d", $signed(e.ref_i),
               $signed(data[45:21]));
        fail_count++;
      end
      if (data[77:46] !== e.ind_i) begin
        $error("inductor_current: expected %0d, got %0d", $signed(e.ind_i),
               $signed(data[77:46]));
        fail_count++;
      end
      if (last !== e.cyc_end) begin
        $error("cycle_end: expected %0d, got %0d", e.cyc_end, last);
        fail_count++;
      end
    endfunction
  endclass

  // Clock, reset and every input of the block start at known values.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Idling odds in percent for the sender and the receiver, set per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The main sequence asks for the long hold-off; the receiver counts it.
  logic hold_request = 1'b0;
  bit   hold_done    = 1'b0;
  int   hold_left    = 0;

  plant_scoreboard sb = new();

  always #4 clk_i = ~clk_i;

  inverter_rl_plant_step u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // Receiver. Values read at the rising edge are those from before the edge,
  // so a word is taken exactly when the block saw both valid and ready high.
  // Ready for the next cycle is then drawn, or held low during the long
  // hold-off so that the block fills up and stops taking ticks.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tdata, m_axis_tlast);
    end
    if (hold_request && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Mostly the two diagonals, as a real modulator switches them, with the
  // odd dead-time word and an occasional arbitrary pattern, shoot-through
  // included.
  function automatic logic [3:0] next_gate_pattern();
    case ($urandom_range(9))
      0, 1, 2, 3: return GATES_POSITIVE;
      4, 5, 6, 7: return GATES_NEGATIVE;
      8:          return GATES_OFF;
      default:    return 4'($urandom_range(15));
    endcase
  endfunction

  // Offers one tick and returns once it has been accepted. The valid line is
  // only lowered while idling, so it never gets two updates in one step.
  task automatic send_tick(input logic [3:0] gates);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, gates};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    sb.note_tick(gates);
  endtask

  // Writes one register per cycle; the enable is dropped by the caller once
  // the whole batch has gone in.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  // Loads a full register set, followed by a write to the unused index that
  // must change nothing.
  task automatic configure(input logic [31:0] ps, input logic [31:0] sc,
                           input logic [31:0] vc, input logic [31:0] dc,
                           input logic [31:0] gp, input logic [31:0] rp,
                           input logic [31:0] st);
    write_reg(irps_pkg::CFG_PHASE_STEP, ps);
    write_reg(irps_pkg::CFG_STATE_COEFF, sc);
    write_reg(irps_pkg::CFG_VOLTAGE_COEFF, vc);
    write_reg(irps_pkg::CFG_DC_LINK, dc);
    write_reg(irps_pkg::CFG_GRID_PEAK, gp);
    write_reg(irps_pkg::CFG_REF_PEAK, rp);
    write_reg(irps_pkg::CFG_STEPS, st);
    write_reg(CFG_UNUSED_IDX, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // Sends a run of ticks under the given idling odds and waits until every
  // word has come back, so that the block is idle at the end.
  task automatic run_phase(input int n_ticks, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n_ticks) begin
      send_tick(next_gate_pattern());
    end
    s_axis_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (2) @(posedge clk_i);
  endtask

  // A hung handshake ends the run here.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int idle_modes[4];
    int stall_modes[4];
    idle_modes  = '{0, 64, 0, 21};
    stall_modes = '{0, 0, 64, 21};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every gate combination at the reset settings, back to back, then a
    // stretch of ordinary switching.
    for (int g = 0; g < 16; g++) begin
      send_tick(4'(g));
    end
    run_phase(200, 0, 0);

    // Every register at its top value: the current runs into both saturation
    // bounds and the tick counter never reaches the end of its period.
    configure(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h000F_FFFF,
              32'h000F_FFFF, 32'h00FF_FFFF, 32'h0000_03FF);
    run_phase(150, 64, 0);

    // Every register at zero: the period of zero wraps the counter on each
    // tick, starting from a count far above the new period.
    configure('0, '0, '0, '0, '0, '0, '0);
    run_phase(100, 0, 64);

    // Random settings: half near a working plant with a short period, half
    // with arbitrary words on the data bus.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 2 == 0) begin
        configure($urandom_range(32'h0100_0000), 32'd1073741824 - $urandom_range(100000),
                  $urandom_range(4_000_000), $urandom_range(32'h000F_FFFF),
                  $urandom_range(32'h000F_FFFF), $urandom_range(32'h00FF_FFFF),
                  $urandom_range(60, 1));
      end else begin
        configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      run_phase(170, idle_modes[ph % 4], stall_modes[ph % 4]);
    end

    // Back pressure: the receiver holds off for a long stretch while ticks
    // keep coming, so the block fills up and stops accepting.
    configure(irps_pkg::RST_PHASE_STEP, irps_pkg::RST_STATE_COEFF,
              irps_pkg::RST_VOLTAGE_COEFF, irps_pkg::RST_DC_LINK,
              irps_pkg::RST_GRID_PEAK, irps_pkg::RST_REF_PEAK,
              $urandom_range(10, 1));
    hold_request <= 1'b1;
    run_phase(80, 0, 0);

    repeat (TICK_LATENCY + 8) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/irps_pkg.sv
hw/rtl/inverter_rl_plant_step.sv
test/testbench.sv
